/* rtl/rth_pkg.sv */
// rth_pkg: shared types and constants of the rgb to hsi converter
// used by rth_cell, rth_finish and rgb_to_hsi_converter; no dependencies
package rth_pkg;

    localparam int XW          = 30;   // cordic x/y width, signed
    localparam int ZW          = 28;   // cordic angle width, signed q24
    localparam int DW          = 27;   // divider remainder width
    localparam int VW          = 11;   // divisor width (2 * sum)
    localparam int QW          = 17;   // quotient width
    localparam int CORDIC_STEPS = 20;
    localparam int DIV_STEPS    = QW;

    localparam logic [15:0]   HUE_GRAY       = 16'd12868;
    localparam logic [15:0]   HUE_TWO_PI     = 16'd51472;
    localparam logic [15:0]   SAT_ONE        = 16'd65535;
    localparam logic [ZW-1:0] HUE_PI_Q24     = ZW'(52707179);
    localparam logic [ZW-1:0] HUE_HALFPI_Q24 = ZW'(26353589);
    localparam logic [ZW-1:0] ROUND_Q13      = ZW'(1024);
    localparam logic [16:0]   SQRT3_Q16      = 17'd113512;
    localparam logic [21:0]   RECIP6_Q24     = 22'd2796203;

    localparam logic [ZW-1:0] ATAN_Q24 [CORDIC_STEPS] = '{
        ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331), ZW'(1047214),
        ZW'(524117),   ZW'(262123),  ZW'(131069),  ZW'(65536),   ZW'(32768),
        ZW'(16384),    ZW'(8192),    ZW'(4096),    ZW'(2048),    ZW'(1024),
        ZW'(512),      ZW'(256),     ZW'(128),     ZW'(64),      ZW'(32)
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [DW-1:0]        rem;
        logic [VW-1:0]        div;
        logic [QW-1:0]        quo;
        logic [15:0]          intensity;
        logic                 gray;
        logic                 mirror;
        logic                 black;
    } cell_data_t;

endpackage

/* rtl/rth_cell.sv */
// rth_cell: one pipeline cell, one cordic rotation and, for IDX below DIV_STEPS, one divider bit
// depends on rth_pkg
module rth_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rth_pkg::cell_data_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rth_pkg::cell_data_t out_data
);

    logic                valid_reg;
    rth_pkg::cell_data_t data_reg;
    rth_pkg::cell_data_t data_next;
    logic signed [rth_pkg::XW-1:0] xs;
    logic signed [rth_pkg::XW-1:0] ys;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign xs = in_data.x >>> IDX;
    assign ys = in_data.y >>> IDX;

    generate
        if (IDX < rth_pkg::DIV_STEPS) begin : g_div
            localparam int QB = rth_pkg::QW - 1 - IDX;
            logic [rth_pkg::DW-1:0] dsh;
            assign dsh = rth_pkg::DW'(in_data.div) << QB;
            always_comb
            begin
                data_next = in_data;
                if (!in_data.y[rth_pkg::XW-1])
                begin
                    data_next.x = in_data.x + ys;
                    data_next.y = in_data.y - xs;
                    data_next.z = in_data.z + $signed(rth_pkg::ATAN_Q24[IDX]);
                end
                else
                begin
                    data_next.x = in_data.x - ys;
                    data_next.y = in_data.y + xs;
                    data_next.z = in_data.z - $signed(rth_pkg::ATAN_Q24[IDX]);
                end
                if (in_data.rem >= dsh)
                begin
                    data_next.rem     = in_data.rem - dsh;
                    data_next.quo[QB] = 1'b1;
                end
            end
        end
        else begin : g_nodiv
            always_comb
            begin
                data_next = in_data;
                if (!in_data.y[rth_pkg::XW-1])
                begin
                    data_next.x = in_data.x + ys;
                    data_next.y = in_data.y - xs;
                    data_next.z = in_data.z + $signed(rth_pkg::ATAN_Q24[IDX]);
                end
                else
                begin
                    data_next.x = in_data.x - ys;
                    data_next.y = in_data.y + xs;
                    data_next.z = in_data.z - $signed(rth_pkg::ATAN_Q24[IDX]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* rtl/rth_finish.sv */
// rth_finish: angle clamp and rounding, special cases, output register
// depends on rth_pkg
module rth_finish (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rth_pkg::cell_data_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         hue,
    output logic [15:0]         saturation,
    output logic [15:0]         intensity
);

    logic        valid_reg;
    logic [15:0] hue_reg;
    logic [15:0] sat_reg;
    logic [15:0] int_reg;
    logic [15:0] hue_next;
    logic [15:0] sat_next;
    logic [rth_pkg::ZW-1:0] zc;
    logic [rth_pkg::ZW-1:0] zr;
    logic [15:0] theta;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign intensity  = int_reg;

    always_comb
    begin
        if (in_data.z[rth_pkg::ZW-1])
            zc = '0;
        else if (in_data.z > $signed(rth_pkg::HUE_PI_Q24))
            zc = rth_pkg::HUE_PI_Q24;
        else
            zc = in_data.z;
        zr    = zc + rth_pkg::ROUND_Q13;
        theta = 16'(zr >> 11);
        if (in_data.gray)
            hue_next = rth_pkg::HUE_GRAY;
        else if (in_data.mirror)
            hue_next = rth_pkg::HUE_TWO_PI - theta;
        else
            hue_next = theta;
        if (in_data.black || in_data.quo[rth_pkg::QW-1])
            sat_next = rth_pkg::SAT_ONE;
        else
            sat_next = in_data.quo[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            int_reg <= in_data.intensity;
        end
    end

endmodule

/* rtl/rgb_to_hsi_converter.sv */
// rgb_to_hsi_converter: top level, pixel setup, chain of cells, finish stage
// depends on rth_pkg, rth_cell, rth_finish
//
// usage
//   input stream s_axis: one rgb pixel per request, tdata = red, green, blue
//   output stream m_axis: one hsi result per pixel, tdata = hue, saturation,
//   intensity; hue in radians q3.13, saturation and intensity q0.16
//   path: an accepted request passes through the 20 cordic cells (those
//   below DIV_STEPS also resolve one quotient bit of the saturation
//   divide each) and then the output register
//   throughput: one pixel per cycle while not stalled; each cell holds one
//   pixel and passes it on unless stalled, so up to 21 pixels are in flight
//   stall: each cell has its own valid bit; when m_axis_tready is low the
//   results back up cell by cell and s_axis_tready drops only once the
//   whole chain is full, so bubbles are squeezed out
//   reset: rst_n clears all valid bits; no request is in flight afterwards
//   and the block can accept a pixel on the first cycle after reset
module rgb_to_hsi_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // hue[15:0], saturation[31:16], intensity[47:32]
);

    localparam int NCELL = rth_pkg::CORDIC_STEPS;

    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] sum;
    logic [7:0] mn;
    logic signed [9:0] n_val;
    logic signed [8:0] d_val;
    logic [7:0]  d_abs;
    logic [24:0] y_mag;
    logic signed [rth_pkg::XW-1:0] x0;
    logic signed [rth_pkg::XW-1:0] y0;
    logic [9:0]  diff;
    logic [25:0] num;
    logic [18:0] t_int;
    logic [40:0] t_prod;
    rth_pkg::cell_data_t prep;

    logic                valid_c [NCELL+1];
    logic                ready_c [NCELL+1];
    rth_pkg::cell_data_t data_c  [NCELL+1];

    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] intensity;

    assign red   = s_axis_tdata[7:0];
    assign green = s_axis_tdata[15:8];
    assign blue  = s_axis_tdata[23:16];

    // pixel setup: vector for the cordic, dividend and divisor, intensity
    always_comb
    begin
        sum   = 10'(red) + 10'(green) + 10'(blue);
        mn    = red;
        if (green < mn)
            mn = green;
        if (blue < mn)
            mn = blue;
        n_val = $signed({2'b00, red} << 1) - $signed({2'b00, green})
                - $signed({2'b00, blue});
        d_val = $signed({1'b0, green}) - $signed({1'b0, blue});
        d_abs = d_val[8] ? 8'(-d_val) : d_val[7:0];
        y_mag = 25'(d_abs) * 25'(rth_pkg::SQRT3_Q16);
        x0    = rth_pkg::XW'(n_val) <<< 16;
        y0    = $signed({{(rth_pkg::XW-25){1'b0}}, y_mag});

        prep = '0;
        if (x0 < 0)
        begin
            // start from a quarter turn so the cordic range covers the left half
            prep.x = y0;
            prep.y = -x0;
            prep.z = $signed(rth_pkg::HUE_HALFPI_Q24);
        end
        else
        begin
            prep.x = x0;
            prep.y = y0;
            prep.z = '0;
        end

        // saturation: round(65535 * diff / sum) as floor((2 num + sum) / (2 sum))
        diff      = sum - 10'(3 * mn);
        num       = (26'(diff) << 16) - 26'(diff);
        prep.rem  = (rth_pkg::DW'(num) << 1) + rth_pkg::DW'(sum);
        prep.div  = {sum, 1'b0};
        prep.quo  = '0;

        // intensity: floor((514 sum + 3) / 6) through a reciprocal
        t_int          = 19'(sum) * 19'd514 + 19'd3;
        t_prod         = 41'(t_int) * 41'(rth_pkg::RECIP6_Q24);
        prep.intensity = t_prod[39:24];

        prep.gray   = (red == green) && (green == blue);
        prep.mirror = blue > green;
        prep.black  = sum == 10'd0;
    end

    assign valid_c[0]    = s_axis_tvalid;
    assign data_c[0]     = prep;
    assign s_axis_tready = ready_c[0];

    generate
        for (genvar i = 0; i < NCELL; i++) begin : g_cell
            rth_cell #(
                .IDX (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (valid_c[i]),
                .in_ready  (ready_c[i]),
                .in_data   (data_c[i]),
                .out_valid (valid_c[i+1]),
                .out_ready (ready_c[i+1]),
                .out_data  (data_c[i+1])
            );
        end
    endgenerate

    rth_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_c[NCELL]),
        .in_ready   (ready_c[NCELL]),
        .in_data    (data_c[NCELL]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .intensity  (intensity)
    );

    assign m_axis_tdata = {intensity, saturation, hue};

endmodule

/* tb/sv/rgb_to_hsi_converter_tb.sv */
// rgb_to_hsi_converter_tb: self-checking testbench of the rgb to hsi converter
// predicts hue, saturation and intensity per pixel and checks the output stream
// depends on rgb_to_hsi_converter and rth_pkg
`timescale 1ns / 100ps

// holds predicted hsi results in request order and compares the output stream
class hsi_scoreboard;
    logic [47:0] pending_hsi[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // cordic angle of (n, |d|), result in q13, in [0, pi]
    static function logic [15:0] hue_angle(int n, int dabs);
        longint x, y, z, t, xs, ys;
        x = longint'(n) * 65536;
        y = longint'(dabs) * 113512;
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = rth_pkg::HUE_HALFPI_Q24;
        end
        for (int i = 0; i < rth_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += rth_pkg::ATAN_Q24[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= rth_pkg::ATAN_Q24[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > rth_pkg::HUE_PI_Q24)
            z = rth_pkg::HUE_PI_Q24;
        return 16'((z + 1024) >>> 11);
    endfunction

    // note an accepted pixel and queue its predicted result
    function void note_pixel(logic [23:0] px);
        int r, g, b, sum, mn, n, d;
        longint num, sat, inten;
        logic [15:0] hue, theta;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        sum = r + g + b;
        mn = r;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
        if (r == g && g == b)
            hue = rth_pkg::HUE_GRAY;
        else
        begin
            n = 2 * r - g - b;
            d = g - b;
            theta = hue_angle(n, d < 0 ? -d : d);
            hue = (b > g) ? rth_pkg::HUE_TWO_PI - theta : theta;
        end
        if (sum == 0)
            sat = 65535;
        else
        begin
            num = longint'(sum - 3 * mn) * 65535;
            sat = (2 * num + sum) / (2 * longint'(sum));
            if (sat > 65535)
                sat = 65535;
        end
        inten = (longint'(sum) * 514 + 3) / 6;
        if (inten > 65535)
            inten = 65535;
        pending_hsi.push_back({inten[15:0], sat[15:0], hue});
    endfunction

    // compare an output result with the oldest prediction
    function void check_result(logic [47:0] got);
        logic [47:0] exp_hsi;
        if (pending_hsi.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_hsi = pending_hsi.pop_front();
        if (got[15:0] !== exp_hsi[15:0])
        begin
            $display("%0t: hue expected %0d actual %0d", $time, exp_hsi[15:0], got[15:0]);
            errors++;
        end
        if (got[31:16] !== exp_hsi[31:16])
        begin
            $display("%0t: saturation expected %0d actual %0d", $time,
                     exp_hsi[31:16], got[31:16]);
            errors++;
        end
        if (got[47:32] !== exp_hsi[47:32])
        begin
            $display("%0t: intensity expected %0d actual %0d", $time,
                     exp_hsi[47:32], got[47:32]);
            errors++;
        end
    endfunction
endclass

module rgb_to_hsi_converter_tb;

    localparam int LATENCY     = 21;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // hue[15:0], saturation[31:16], intensity[47:32]

    hsi_scoreboard board;
    int  send_idle_pct;    // chance per cycle that the sender idles
    int  recv_stall_pct;   // chance per cycle that the receiver stalls
    bit  hold_off;         // long receiver hold-off in progress
    int  cycles;

    rgb_to_hsi_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // note accepted requests and check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one pixel, idling at random first, and wait until it is taken;
    // valid stays high afterwards so pixels can follow back to back
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random pixel, biased toward gray, near-gray and extreme channels
    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(9))
            0: begin g = r; b = r; end
            1:
            begin
                g = r + 8'($urandom_range(2)) - 8'd1;
                b = r + 8'($urandom_range(2)) - 8'd1;
            end
            2: begin r = $urandom_range(1) ? 8'hff : 8'h00; end
            3: begin g = b; end
            4:
            begin
                r = 8'($urandom_range(7));
                g = 8'($urandom_range(7));
                b = 8'($urandom_range(7));
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    // sender is idle; wait until every predicted result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (board.pending_hsi.size() != 0);
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: black, white, primaries, secondaries, gray, mirror edges
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd0,   8'd255, 8'd254);
        send_pixel(8'd0,   8'd254, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd85);
        send_pixel(8'd85,  8'd170, 8'd170);
        send_pixel(8'd10,  8'd200, 8'd100);
        send_pixel(8'd10,  8'd100, 8'd200);
        send_pixel(8'd127, 8'd128, 8'd129);
        send_pixel(8'd85,  8'd170, 8'd255);

        // phases of idling: none, sender, receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 77 : 24) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 77 : 24) : 0;
            for (int k = 0; k < 300; k++)
            begin
                if ($urandom_range(59) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (1 + $urandom_range(39)) @(negedge clk);
                end
                send_random_pixel();
            end
            // sender pauses until every result is back
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        // long receiver hold-off while the sender keeps offering pixels
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 100; k++)
                    send_random_pixel();
                s_axis_tvalid <= 1'b0;
            end
        join

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0 && board.pending_hsi.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
